// File: rtl/core/llcp_pkg.sv
`default_nettype none
package llcp_pkg;

   // field and intermediate widths
   localparam int CRD_W  = 32;               // Q16.16 coordinate
   localparam int DIF_W  = CRD_W + 1;        // point difference
   localparam int MP_W   = CRD_W + DIF_W;    // one coordinate product
   localparam int DOT_W  = MP_W + 3;         // sum of three products
   localparam int LIMB_W = 32;               // partial product limb
   localparam int LIMB_N = (DOT_W + LIMB_W - 1) / LIMB_W;
   localparam int MAG_W  = LIMB_W * LIMB_N;
   localparam int PP_W   = 2 * LIMB_W;
   localparam int ROW_W  = LIMB_W * (LIMB_N + 1);
   localparam int PROD_W = 2 * DOT_W;        // wide product and difference
   localparam int FRAC_W = 16;
   localparam int QUO_W  = 32;
   localparam int DNUM_W = PROD_W + FRAC_W;  // scaled dividend magnitude
   localparam int DREM_W = PROD_W + QUO_W;   // compare width in divider
   localparam int SUM_W  = 2 * CRD_W - FRAC_W + 1;
   localparam int THR_SHIFT = 32;

   // pipeline depth
   localparam int MUL_LAT = 5;
   localparam int DIV_LAT = 35;
   localparam int LVL_DOT = 3;
   localparam int LVL_DIF = LVL_DOT + MUL_LAT + 1;
   localparam int LVL_ABS = LVL_DIF + 1;
   localparam int LVL_SEL = LVL_ABS + 1;
   localparam int LVL_DIV = LVL_SEL + DIV_LAT;
   localparam int LVL_OUT = LVL_DIV + 2;

   localparam logic [CRD_W-1:0] THR_RESET = 32'd4295;

   typedef logic signed [CRD_W-1:0]  crd_type;
   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam crd_type CRD_MAX = 32'sh7FFF_FFFF;
   localparam crd_type CRD_MIN = 32'sh8000_0000;

   typedef struct packed {
      crd_type [2:0] p1;
      crd_type [2:0] d1;
      crd_type [2:0] p2;
      crd_type [2:0] d2;
   } line_pair_type;

   // saturate a widened sum to a coordinate
   function automatic crd_type sat_crd(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      crd_type r;
      hi = SUM_W'(CRD_MAX);
      lo = SUM_W'(CRD_MIN);
      if (v > hi) begin
         r = CRD_MAX;
      end else if (v < lo) begin
         r = CRD_MIN;
      end else begin
         r = v[CRD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/llcp_req_if.sv
`default_nettype none
interface llcp_req_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     first_point_x;
   logic signed [31:0]     first_point_y;
   logic signed [31:0]     first_point_z;
   logic signed [31:0]     first_dir_x;
   logic signed [31:0]     first_dir_y;
   logic signed [31:0]     first_dir_z;
   logic signed [31:0]     second_point_x;
   logic signed [31:0]     second_point_y;
   logic signed [31:0]     second_point_z;
   logic signed [31:0]     second_dir_x;
   logic signed [31:0]     second_dir_y;
   logic signed [31:0]     second_dir_z;

   modport source (
      output valid, first_point_x, first_point_y, first_point_z,
      output first_dir_x, first_dir_y, first_dir_z,
      output second_point_x, second_point_y, second_point_z,
      output second_dir_x, second_dir_y, second_dir_z,
      input  ready
   );
   modport sink (
      input  valid, first_point_x, first_point_y, first_point_z,
      input  first_dir_x, first_dir_y, first_dir_z,
      input  second_point_x, second_point_y, second_point_z,
      input  second_dir_x, second_dir_y, second_dir_z,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/core/llcp_rsp_if.sv
`default_nettype none
interface llcp_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     param_first;
   logic signed [31:0]     param_second;
   logic signed [31:0]     near_first_x;
   logic signed [31:0]     near_first_y;
   logic signed [31:0]     near_first_z;
   logic signed [31:0]     near_second_x;
   logic signed [31:0]     near_second_y;
   logic signed [31:0]     near_second_z;
   logic                   parallel_flag;

   modport source (
      output valid, param_first, param_second,
      output near_first_x, near_first_y, near_first_z,
      output near_second_x, near_second_y, near_second_z, parallel_flag,
      input  ready
   );
   modport sink (
      input  valid, param_first, param_second,
      input  near_first_x, near_first_y, near_first_z,
      input  near_second_x, near_second_y, near_second_z, parallel_flag,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/core/llcp_wmul.sv
`default_nettype none
module llcp_wmul (
   input  logic               clock,
   input  logic               en,
   input  llcp_pkg::dot_type  x,
   input  llcp_pkg::dot_type  y,
   output llcp_pkg::prod_type p
);
   import llcp_pkg::*;

   logic [DOT_W-1:0]  xa_in, ya_in;
   logic [MAG_W-1:0]  xm_ff, ym_ff;
   logic [3:0]        sgn_ff;
   logic [PP_W-1:0]   pp_ff [LIMB_N][LIMB_N];
   logic [ROW_W-1:0]  row_ff [LIMB_N];
   logic [ROW_W-1:0]  row_in [LIMB_N];
   logic [PROD_W-1:0] tot_ff, tot_in;
   prod_type          p_ff;

   // magnitudes of the operands
   always_comb begin
      xa_in = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
      ya_in = y[DOT_W-1] ? DOT_W'(-y) : DOT_W'(y);
   end

   // row sums and total of the limb products
   always_comb begin
      for (int i = 0; i < LIMB_N; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < LIMB_N; j++) begin
            row_in[i] = row_in[i] + (ROW_W'(pp_ff[i][j]) << (LIMB_W * j));
         end
      end
      tot_in = '0;
      for (int i = 0; i < LIMB_N; i++) begin
         tot_in = tot_in + (PROD_W'(row_ff[i]) << (LIMB_W * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xm_ff  <= MAG_W'(xa_in);
         ym_ff  <= MAG_W'(ya_in);
         sgn_ff <= {sgn_ff[2:0], x[DOT_W-1] ^ y[DOT_W-1]};
         for (int i = 0; i < LIMB_N; i++) begin
            for (int j = 0; j < LIMB_N; j++) begin
               pp_ff[i][j] <= PP_W'(xm_ff[i*LIMB_W +: LIMB_W])
                            * PP_W'(ym_ff[j*LIMB_W +: LIMB_W]);
            end
         end
         row_ff <= row_in;
         tot_ff <= tot_in;
         p_ff   <= sgn_ff[3] ? -$signed(tot_ff) : $signed(tot_ff);
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// File: rtl/core/llcp_div.sv
`default_nettype none
module llcp_div (
   input  logic               clock,
   input  logic               en,
   input  llcp_pkg::prod_type n,
   input  llcp_pkg::prod_type d,
   output llcp_pkg::crd_type  q
);
   import llcp_pkg::*;

   logic              neg1_ff;
   logic [DNUM_W-1:0] un1_ff;
   logic [PROD_W-1:0] ud1_ff;
   logic [PROD_W-1:0] na_in, da_in;

   logic [DNUM_W-1:0] rem_ff [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff [QUO_W+1];
   logic [PROD_W-1:0] ud_ff  [QUO_W+1];
   logic              neg_ff [QUO_W+1];
   logic              ovf_ff [QUO_W+1];

   logic [QUO_W-1:0]  lim_in, mag_in;
   crd_type           q_ff;

   // sign and magnitudes, dividend scaled to Q16.16
   always_comb begin
      na_in = n[PROD_W-1] ? PROD_W'(-n) : PROD_W'(n);
      da_in = d[PROD_W-1] ? PROD_W'(-d) : PROD_W'(d);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff   <= n[PROD_W-1] ^ d[PROD_W-1];
         un1_ff    <= DNUM_W'(na_in) << FRAC_W;
         ud1_ff    <= da_in;
         // quotient too large for 32 bits
         ovf_ff[0] <= DREM_W'(un1_ff) >= (DREM_W'(ud1_ff) << QUO_W);
         rem_ff[0] <= un1_ff;
         quo_ff[0] <= '0;
         ud_ff[0]  <= ud1_ff;
         neg_ff[0] <= neg1_ff;
      end
   end

   // one restoring step per stage, msb first
   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      logic [DREM_W-1:0] trial;
      logic              fit;
      assign trial = DREM_W'(ud_ff[s]) << (QUO_W - 1 - s);
      assign fit   = DREM_W'(rem_ff[s]) >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= fit ? DNUM_W'(DREM_W'(rem_ff[s]) - trial) : rem_ff[s];
            quo_ff[s+1] <= quo_ff[s] | (fit ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);
            ud_ff[s+1]  <= ud_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   // saturate and apply sign
   always_comb begin
      lim_in = neg_ff[QUO_W] ? QUO_W'(CRD_MIN) : QUO_W'(CRD_MAX);
      mag_in = (ovf_ff[QUO_W] || quo_ff[QUO_W] > lim_in) ? lim_in : quo_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= neg_ff[QUO_W] ? -$signed(mag_in) : $signed(mag_in);
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

// File: rtl/core/line_line_closest_points_top.sv
`default_nettype none
// Closest points between two 3D lines in signed Q16.16. The block is fully
// pipelined: it takes one line pair per cycle while rsp_ch is not stalled.
// The depth is set by the 32-stage restoring divider (one quotient bit per
// stage) and the five-stage limb multiplier for the wide products; a stall
// on rsp_ch holds the whole pipeline, and req_ch.ready follows it in the
// same cycle.
// csr_wr_data sets the parallel threshold in units of 2^-32 (reset 4295);
// write it only while no item is in flight.
module line_line_closest_points_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   llcp_req_if.sink    req_ch,
   llcp_rsp_if.source  rsp_ch
);
   import llcp_pkg::*;

   typedef struct packed {
      dot_type c;
      dot_type e;
   } ce_type;

   typedef struct packed {
      crd_type       t1;
      crd_type       t2;
      crd_type [2:0] n1;
      crd_type [2:0] n2;
      logic          par;
   } out_type;

   logic                adv;
   logic [CRD_W-1:0]    thr_ff;
   logic                vld_ff [LVL_OUT+1];
   line_pair_type       line_ff [LVL_DIV+1];
   line_pair_type       line_in;

   logic signed [DIF_W-1:0] w_ff [3];
   logic signed [MP_W-1:0]  prd_ff [5][3];
   dot_type                 dot_ff [5];
   ce_type                  ce_ff [LVL_DOT+1:LVL_ABS];

   prod_type            ac, bb, be, cd, ae, bd;
   prod_type            den_ff, n1_ff, n2_ff;
   prod_type            den2_ff, n12_ff, n22_ff;
   logic [PROD_W-1:0]   dabs_ff;
   logic                dz_ff;
   logic                par_in, cz_in;
   prod_type            dn_ff [2];
   prod_type            dd_ff [2];
   logic                par_ff [LVL_SEL:LVL_DIV+1];
   crd_type             t1, t2;

   crd_type                 t1_ff, t2_ff;
   logic signed [2*CRD_W-1:0] tp_ff [2][3];
   crd_type [2:0]           pa_ff, pb_ff;
   out_type                 out_ff;

   // global advance: move when the output stage is empty or drained
   assign adv          = !vld_ff[LVL_OUT] || rsp_ch.ready;
   assign req_ch.ready = adv;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LVL_OUT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
         for (int k = 1; k <= LVL_OUT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // input capture and line data delay
   always_comb begin
      line_in.p1[0] = req_ch.first_point_x;
      line_in.p1[1] = req_ch.first_point_y;
      line_in.p1[2] = req_ch.first_point_z;
      line_in.d1[0] = req_ch.first_dir_x;
      line_in.d1[1] = req_ch.first_dir_y;
      line_in.d1[2] = req_ch.first_dir_z;
      line_in.p2[0] = req_ch.second_point_x;
      line_in.p2[1] = req_ch.second_point_y;
      line_in.p2[2] = req_ch.second_point_z;
      line_in.d2[0] = req_ch.second_dir_x;
      line_in.d2[1] = req_ch.second_dir_y;
      line_in.d2[2] = req_ch.second_dir_z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= line_in;
         for (int k = 1; k <= LVL_DIV; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   // point difference, coordinate products, dot products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            w_ff[i] <= DIF_W'($signed(line_ff[0].p1[i])) - DIF_W'($signed(line_ff[0].p2[i]));
            prd_ff[0][i] <= MP_W'($signed(line_ff[1].d1[i])) * MP_W'($signed(line_ff[1].d1[i]));
            prd_ff[1][i] <= MP_W'($signed(line_ff[1].d1[i])) * MP_W'($signed(line_ff[1].d2[i]));
            prd_ff[2][i] <= MP_W'($signed(line_ff[1].d2[i])) * MP_W'($signed(line_ff[1].d2[i]));
            prd_ff[3][i] <= MP_W'($signed(line_ff[1].d1[i])) * MP_W'(w_ff[i]);
            prd_ff[4][i] <= MP_W'($signed(line_ff[1].d2[i])) * MP_W'(w_ff[i]);
         end
         for (int k = 0; k < 5; k++) begin
            dot_ff[k] <= DOT_W'(prd_ff[k][0]) + DOT_W'(prd_ff[k][1]) + DOT_W'(prd_ff[k][2]);
         end
      end
   end

   // wide products: a*c, b*b, b*e, c*d, a*e, b*d
   llcp_wmul u_mul_ac (.clock(clock), .en(adv), .x(dot_ff[0]), .y(dot_ff[2]), .p(ac));
   llcp_wmul u_mul_bb (.clock(clock), .en(adv), .x(dot_ff[1]), .y(dot_ff[1]), .p(bb));
   llcp_wmul u_mul_be (.clock(clock), .en(adv), .x(dot_ff[1]), .y(dot_ff[4]), .p(be));
   llcp_wmul u_mul_cd (.clock(clock), .en(adv), .x(dot_ff[2]), .y(dot_ff[3]), .p(cd));
   llcp_wmul u_mul_ae (.clock(clock), .en(adv), .x(dot_ff[0]), .y(dot_ff[4]), .p(ae));
   llcp_wmul u_mul_bd (.clock(clock), .en(adv), .x(dot_ff[1]), .y(dot_ff[3]), .p(bd));

   // c and e wait for the parallel decision
   always_ff @(posedge clock) begin
      if (adv) begin
         ce_ff[LVL_DOT+1] <= '{c: dot_ff[2], e: dot_ff[4]};
         for (int k = LVL_DOT + 2; k <= LVL_ABS; k++) begin
            ce_ff[k] <= ce_ff[k-1];
         end
      end
   end

   // denominator and numerators, then denominator magnitude
   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= ac - bb;
         n1_ff   <= be - cd;
         n2_ff   <= ae - bd;
         dabs_ff <= den_ff[PROD_W-1] ? PROD_W'(-den_ff) : PROD_W'(den_ff);
         dz_ff   <= (den_ff == '0);
         den2_ff <= den_ff;
         n12_ff  <= n1_ff;
         n22_ff  <= n2_ff;
      end
   end

   // parallel test and divider operand select
   always_comb begin
      par_in = dz_ff || (dabs_ff < (PROD_W'(thr_ff) << THR_SHIFT));
      cz_in  = (ce_ff[LVL_ABS].c == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         par_ff[LVL_SEL] <= par_in;
         if (par_in) begin
            dn_ff[0] <= '0;
            dd_ff[0] <= PROD_W'(1);
            dn_ff[1] <= cz_in ? '0 : PROD_W'(ce_ff[LVL_ABS].e);
            dd_ff[1] <= cz_in ? PROD_W'(1) : PROD_W'(ce_ff[LVL_ABS].c);
         end else begin
            dn_ff[0] <= n12_ff;
            dd_ff[0] <= den2_ff;
            dn_ff[1] <= n22_ff;
            dd_ff[1] <= den2_ff;
         end
         for (int k = LVL_SEL + 1; k <= LVL_DIV + 1; k++) begin
            par_ff[k] <= par_ff[k-1];
         end
      end
   end

   llcp_div u_div_t1 (.clock(clock), .en(adv), .n(dn_ff[0]), .d(dd_ff[0]), .q(t1));
   llcp_div u_div_t2 (.clock(clock), .en(adv), .n(dn_ff[1]), .d(dd_ff[1]), .q(t2));

   // closest points: scale directions, then add and saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= t1;
         t2_ff <= t2;
         pa_ff <= line_ff[LVL_DIV].p1;
         pb_ff <= line_ff[LVL_DIV].p2;
         for (int i = 0; i < 3; i++) begin
            tp_ff[0][i] <= (2*CRD_W)'(t1) * (2*CRD_W)'($signed(line_ff[LVL_DIV].d1[i]));
            tp_ff[1][i] <= (2*CRD_W)'(t2) * (2*CRD_W)'($signed(line_ff[LVL_DIV].d2[i]));
         end
         out_ff.t1  <= t1_ff;
         out_ff.t2  <= t2_ff;
         out_ff.par <= par_ff[LVL_DIV + 1];
         for (int i = 0; i < 3; i++) begin
            out_ff.n1[i] <= sat_crd(SUM_W'($signed(pa_ff[i]))
                                    + SUM_W'(tp_ff[0][i] >>> FRAC_W));
            out_ff.n2[i] <= sat_crd(SUM_W'($signed(pb_ff[i]))
                                    + SUM_W'(tp_ff[1][i] >>> FRAC_W));
         end
      end
   end

   // result channel
   assign rsp_ch.valid         = vld_ff[LVL_OUT];
   assign rsp_ch.param_first   = out_ff.t1;
   assign rsp_ch.param_second  = out_ff.t2;
   assign rsp_ch.near_first_x  = out_ff.n1[0];
   assign rsp_ch.near_first_y  = out_ff.n1[1];
   assign rsp_ch.near_first_z  = out_ff.n1[2];
   assign rsp_ch.near_second_x = out_ff.n2[0];
   assign rsp_ch.near_second_y = out_ff.n2[1];
   assign rsp_ch.near_second_z = out_ff.n2[2];
   assign rsp_ch.parallel_flag = out_ff.par;

endmodule
`default_nettype wire
